### rtl/scnm_pkg.sv
// ----------------------------------------------------------------------------
// scnm_pkg
// Shared types and constants for the stream capture and needle match block.
// ----------------------------------------------------------------------------
package scnm_pkg;

	localparam int NEEDLE_MAX  = 16;
	localparam int STORE_DEPTH = 4096;
	localparam int NEEDLE_IW   = $clog2(NEEDLE_MAX);
	localparam int PROG_W      = $clog2(NEEDLE_MAX + 1);
	localparam int STORE_AW    = $clog2(STORE_DEPTH);
	localparam int CAP_W       = 13;
	localparam int CFG_W       = 64;

	localparam logic [31:0] HASH_BASIS = 32'd2166136261;
	localparam logic [31:0] HASH_PRIME = 32'd16777619;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(STORE_DEPTH);

	typedef enum logic [1:0] {
		CFG_NEEDLE_LOW,
		CFG_NEEDLE_HIGH,
		CFG_NEEDLE_LENGTH,
		CFG_STORE_CAPACITY
	} cfg_idx_t;

	typedef struct packed {
		logic        opcode;
		logic [7:0]  data_byte;
		logic [11:0] read_index;
	} item_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        needle_found;
		logic [4:0]  match_progress;
		logic        store_truncated;
		logic [11:0] stored_count;
		logic [63:0] byte_count;
		logic [31:0] store_hash;
	} result_t;

	// one processed step, shared by matcher and store
	typedef struct packed {
		logic                advance;
		logic                feed;
		logic [7:0]          ch;
		logic [STORE_AW-1:0] read_index;
	} step_t;

	typedef struct packed {
		logic [NEEDLE_MAX-1:0][7:0] bytes;
		logic [4:0]                 length;
		logic                       restart;
	} needle_t;

	typedef struct packed {
		logic              found;
		logic [PROG_W-1:0] progress;
	} match_stat_t;

	typedef struct packed {
		logic [7:0]          read_data;
		logic                truncated;
		logic [STORE_AW-1:0] count;
		logic [31:0]         hash;
	} store_stat_t;

endpackage

### rtl/scnm_match.sv
// ----------------------------------------------------------------------------
// scnm_match
// Needle matcher with naive restart; holds progress and found flag.
// ----------------------------------------------------------------------------
module scnm_match (
	input  logic                  clk,
	input  logic                  arst_n,
	input  scnm_pkg::step_t       step,
	input  scnm_pkg::needle_t     needle,
	output scnm_pkg::match_stat_t stat
);
	import scnm_pkg::*;

	logic [PROG_W-1:0] progress_q;
	logic              found_q;
	logic [PROG_W-1:0] act_len;
	logic [PROG_W-1:0] p0;
	logic [PROG_W-1:0] p_next;
	logic              found_next;
	logic              active;

	always_comb begin
		act_len = (needle.length > 5'(NEEDLE_MAX)) ? PROG_W'(NEEDLE_MAX)
			: PROG_W'(needle.length);
		active = step.feed && !found_q && (act_len != '0);
		p0 = (progress_q >= act_len) ? '0 : progress_q;
		p_next = progress_q;
		found_next = found_q;
		if (active) begin
			if (step.ch == needle.bytes[p0[NEEDLE_IW-1:0]]) begin
				p_next = p0 + PROG_W'(1);
				found_next = (p_next == act_len);
			end else if (p0 != '0) begin
				p_next = (step.ch == needle.bytes[0]) ? PROG_W'(1) : '0;
			end else begin
				p_next = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			progress_q <= '0;
			found_q <= 1'b0;
		end else if (needle.restart) begin
			progress_q <= '0;
			found_q <= 1'b0;
		end else if (step.advance) begin
			progress_q <= p_next;
			found_q <= found_next;
		end
	end

	assign stat.found = found_q;
	assign stat.progress = progress_q;

endmodule

### rtl/scnm_store.sv
// ----------------------------------------------------------------------------
// scnm_store
// Capture memory with fill count, truncation flag and FNV-1a hash.
// ----------------------------------------------------------------------------
module scnm_store (
	input  logic                        clk,
	input  logic                        arst_n,
	input  scnm_pkg::step_t             step,
	input  logic [scnm_pkg::CAP_W-1:0]  capacity,
	output scnm_pkg::store_stat_t       stat
);
	import scnm_pkg::*;

	logic [7:0]          mem [STORE_DEPTH];
	logic [STORE_AW-1:0] len_q;
	logic                trunc_q;
	logic [31:0]         hash_q;
	logic [7:0]          rd_q;
	logic                rd_ok_q;
	logic [CAP_W-1:0]    cap;
	logic                enabled;
	logic                full;
	logic                wr;
	logic [31:0]         hash_next;

	always_comb begin
		cap = (capacity > CAP_W'(STORE_DEPTH)) ? CAP_W'(STORE_DEPTH) : capacity;
		enabled = (cap >= CAP_W'(2));
		full = (CAP_W'(len_q) >= (cap - CAP_W'(1)));
		wr = step.advance && step.feed && enabled && !full;
		hash_next = 32'((hash_q ^ {24'd0, step.ch}) * HASH_PRIME);
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[len_q] <= step.ch;
		end
	end

	always_ff @(posedge clk) begin
		if (step.advance) begin
			rd_q <= mem[step.read_index];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			trunc_q <= 1'b0;
			hash_q <= HASH_BASIS;
			rd_ok_q <= 1'b0;
		end else if (step.advance) begin
			rd_ok_q <= !step.feed && (step.read_index < len_q);
			if (wr) begin
				len_q <= len_q + STORE_AW'(1);
				hash_q <= hash_next;
			end else if (step.feed && enabled) begin
				trunc_q <= 1'b1;
			end
		end
	end

	assign stat.read_data = rd_ok_q ? rd_q : 8'd0;
	assign stat.truncated = trunc_q;
	assign stat.count = len_q;
	assign stat.hash = hash_q;

endmodule

### rtl/stream_capture_needle_match.sv
// ----------------------------------------------------------------------------
// stream_capture_needle_match
// Byte stream capture with needle search, byte count and FNV-1a hash.
// ----------------------------------------------------------------------------
// result path: an accepted item passes the input register, then the match and store state
// throughput: one item per cycle while result_ready holds, bounded by the hash multiply and store port
// stalls: one item waits in the input register while a result is held off
// reset: needle cleared, capacity 4096, hash at FNV basis, store empty
// store contents are not cleared; unwritten entries are masked by the fill count
module stream_capture_needle_match (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  scnm_pkg::item_t             item,
	output logic                        result_valid,
	input  logic                        result_ready,
	output scnm_pkg::result_t           result,
	input  logic                        cfg_we,
	input  scnm_pkg::cfg_idx_t          cfg_index,
	input  logic [scnm_pkg::CFG_W-1:0]  cfg_data
);
	import scnm_pkg::*;

	item_t            item_s1;
	logic             valid_s1;
	logic             valid_s2;
	logic             advance;
	logic [63:0]      needle_low_q;
	logic [63:0]      needle_high_q;
	logic [4:0]       needle_size_q;
	logic [CAP_W-1:0] capacity_q;
	logic [63:0]      byte_count_q;
	step_t            step;
	needle_t          needle;
	match_stat_t      mstat;
	store_stat_t      sstat;

	assign advance = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || advance;
	assign result_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= (item_valid && item_ready) || (valid_s1 && !advance);
			valid_s2 <= advance || (valid_s2 && !result_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_low_q <= '0;
			needle_high_q <= '0;
			needle_size_q <= '0;
			capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NEEDLE_LOW: needle_low_q <= cfg_data;
				CFG_NEEDLE_HIGH: needle_high_q <= cfg_data;
				CFG_NEEDLE_LENGTH: needle_size_q <= cfg_data[4:0];
				CFG_STORE_CAPACITY: capacity_q <= cfg_data[CAP_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
		end else if (advance && !item_s1.opcode) begin
			byte_count_q <= byte_count_q + 64'd1;
		end
	end

	always_comb begin
		step.advance = advance;
		step.feed = !item_s1.opcode;
		step.ch = item_s1.data_byte;
		step.read_index = STORE_AW'(item_s1.read_index);
		needle.bytes = {needle_high_q, needle_low_q};
		needle.length = needle_size_q;
		needle.restart = cfg_we && (cfg_index != CFG_STORE_CAPACITY);
	end

	scnm_match u_match (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.needle (needle),
		.stat   (mstat)
	);

	scnm_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.capacity (capacity_q),
		.stat     (sstat)
	);

	always_comb begin
		result.read_data = sstat.read_data;
		result.needle_found = mstat.found;
		result.match_progress = 5'(mstat.progress);
		result.store_truncated = sstat.truncated;
		result.stored_count = 12'(sstat.count);
		result.byte_count = byte_count_q;
		result.store_hash = sstat.hash;
	end

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1 |=> result.stored_count >= $past(result.stored_count))
		else $error("stored count went down");

	a_hash_tracks_store: assert property (@(posedge clk) disable iff (!arst_n)
		$stable(result.stored_count) |-> $stable(result.store_hash))
		else $error("hash changed without a stored byte");

	a_found_full_match: assert property (@(posedge clk) disable iff (!arst_n)
		result.needle_found |-> (result.match_progress == needle_size_q)
			|| ((needle_size_q > 5'(NEEDLE_MAX))
			&& (result.match_progress == 5'(NEEDLE_MAX))))
		else $error("found without full progress");

	a_byte_count: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !item_s1.opcode) |=> byte_count_q == $past(byte_count_q) + 64'd1)
		else $error("feed not counted");

endmodule
